// File: src/k_subset_mask_enumerator_assert.svh
// assertion macros for the k-subset mask enumerator checker
// expects clk_i and rst_ni to be visible where the macros are used
`ifndef K_SUBSET_MASK_ENUMERATOR_ASSERT_SVH
`define K_SUBSET_MASK_ENUMERATOR_ASSERT_SVH

// property checked at every clock edge outside reset
`define KSE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");

// same, with a message of its own
`define KSE_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

// File: src/kse_pkg.sv
// shared widths and types for the k-subset mask enumerator
// no dependencies
package kse_pkg;

  // width of the enumerated word, also the largest usable bit count
  localparam int unsigned MaskW = 16;
  // width of bit counts and subset sizes
  localparam int unsigned SizeW = 5;
  // width of a bit position within the word
  localparam int unsigned IdxW  = $clog2(MaskW);

  typedef logic [MaskW-1:0] mask_t;
  typedef logic [SizeW-1:0] size_t;
  typedef logic [IdxW-1:0]  idx_t;

endpackage

// File: src/kse_channels.sv
// valid/ready channels of the k-subset mask enumerator
// depends on kse_pkg
interface kse_cfg_if;
  import kse_pkg::*;
  logic  valid;
  logic  ready;
  size_t bit_count;
  modport source (output valid, output bit_count, input ready);
  modport sink   (input valid, input bit_count, output ready);
endinterface

interface kse_req_if;
  logic valid;
  logic ready;
  logic request;
  modport source (output valid, output request, input ready);
  modport sink   (input valid, input request, output ready);
endinterface

interface kse_res_if;
  import kse_pkg::*;
  logic  valid;
  logic  ready;
  mask_t subset_mask;
  mask_t low_ones_mask;
  size_t subset_size;
  logic  done_res;
  modport source (output valid, output subset_mask, output low_ones_mask,
                  output subset_size, output done_res, input ready);
  modport sink   (input valid, input subset_mask, input low_ones_mask,
                  input subset_size, input done_res, output ready);
endinterface

// File: src/k_subset_mask_enumerator.sv
// k-subset mask enumerator top level
// depends on kse_pkg and the channel interfaces in kse_channels.sv
//
// Each item with request set returns one result: the next subset mask of an
// n-bit word (n = bit_count, clamped to 16), grouped by size k from 1 to n and
// in descending order within a size, plus the low-k-ones mask and k. After
// the last mask every request returns done with zero fields; raising
// bit_count afterwards resumes with the next size. Items with request clear
// produce nothing and leave the state alone. One item is taken per cycle,
// back to back, while the result side is not stalled; an item taken into the
// input register passes to the result register once that register is free or
// its result is taken, through the combinational next-mask logic (carry, two
// priority encoders and a shifter) that sits between the two.
// bit_count is to be written only while the block is idle; the block does not
// enforce it. The write channel is always ready.
module k_subset_mask_enumerator (
  input  logic   clk_i,
  input  logic   rst_ni,
  kse_cfg_if.sink   cfg_i,
  kse_req_if.sink   req_i,
  kse_res_if.source res_o
);
  import kse_pkg::*;

  // mask with the low k bits set
  function automatic mask_t ones_below(input size_t k);
    mask_t r;
    for (int i = 0; i < MaskW; i++) begin
      r[i] = (SizeW'(i) < k);
    end
    return r;
  endfunction

  // configuration
  size_t bit_count_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_count_q <= SizeW'(MaskW);
    end else if (cfg_i.valid) begin
      bit_count_q <= cfg_i.bit_count;
    end
  end

  // input register
  logic in_vld_q;
  logic in_req_q;
  logic move;
  logic out_vld_q;

  assign move        = in_vld_q && (!in_req_q || !out_vld_q || res_o.ready);
  assign req_i.ready = !in_vld_q || move;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      in_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_req_q <= req_i.request;
    end
  end

  // enumeration state
  size_t size_q, size_d;
  mask_t mask_q, mask_d;
  logic  fin_q, fin_d;

  // next mask within the running size
  logic [MaskW:0] m_inc;
  mask_t rest;
  mask_t tail;
  mask_t adv_mask;
  idx_t  t_pos;
  idx_t  p_pos;
  idx_t  shamt;
  logic  advanced;

  assign m_inc = {1'b0, mask_q} + 1'b1;
  // clear the trailing ones; tail is those ones plus the zero above them
  assign rest  = mask_q & m_inc[MaskW-1:0];
  assign tail  = mask_q ^ m_inc[MaskW-1:0];

  // lowest zero of the mask and lowest one of what is left
  always_comb begin
    t_pos = '0;
    p_pos = '0;
    for (int i = MaskW - 1; i >= 0; i--) begin
      if (!mask_q[i]) t_pos = IdxW'(i);
      if (rest[i])    p_pos = IdxW'(i);
    end
  end

  assign shamt    = p_pos - t_pos - 1'b1;
  assign adv_mask = (rest & (rest - 1'b1)) | (tail << shamt);
  assign advanced = !fin_q && (rest != '0);

  // opening a new size
  size_t n_eff;
  size_t size_open;
  size_t open_shift;
  mask_t open_mask;
  logic  exhausted;

  assign n_eff      = (bit_count_q > SizeW'(MaskW)) ? SizeW'(MaskW) : bit_count_q;
  assign exhausted  = !advanced && (size_q >= n_eff);
  assign size_open  = size_q + 1'b1;
  assign open_shift = n_eff - size_open;
  assign open_mask  = ones_below(size_open) << open_shift;

  // state update
  always_comb begin
    size_d = size_q;
    mask_d = mask_q;
    fin_d  = fin_q;
    if (advanced) begin
      mask_d = adv_mask;
    end else if (!exhausted) begin
      size_d = size_open;
      mask_d = open_mask;
    end
    if (exhausted) begin
      fin_d = 1'b1;
    end else begin
      fin_d = (mask_d == ones_below(size_d));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= '0;
      mask_q <= '0;
      fin_q  <= 1'b1;
    end else if (move && in_req_q) begin
      size_q <= size_d;
      mask_q <= mask_d;
      fin_q  <= fin_d;
    end
  end

  // result register
  mask_t res_mask_q;
  mask_t res_low_q;
  size_t res_size_q;
  logic  res_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (move && in_req_q) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move && in_req_q) begin
      if (exhausted) begin
        res_mask_q <= '0;
        res_low_q  <= '0;
        res_size_q <= '0;
        res_done_q <= 1'b1;
      end else begin
        res_mask_q <= mask_d;
        res_low_q  <= ones_below(size_d);
        res_size_q <= size_d;
        res_done_q <= 1'b0;
      end
    end
  end

  assign res_o.valid         = out_vld_q;
  assign res_o.subset_mask   = res_mask_q;
  assign res_o.low_ones_mask = res_low_q;
  assign res_o.subset_size   = res_size_q;
  assign res_o.done_res      = res_done_q;

endmodule

// File: src/kse_checker.sv
// port-level checks for the k-subset mask enumerator, bound to the top level
// depends on kse_pkg and k_subset_mask_enumerator_assert.svh
`include "k_subset_mask_enumerator_assert.svh"

module kse_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             res_valid_i,
  input logic             res_ready_i,
  input kse_pkg::mask_t   subset_mask_i,
  input kse_pkg::mask_t   low_ones_mask_i,
  input kse_pkg::size_t   subset_size_i,
  input logic             done_res_i
);
  import kse_pkg::*;

  logic fields_zero;
  logic sizes_agree;
  logic low_contig;

  // payload properties of one result item
  assign fields_zero = (subset_mask_i == '0) && (low_ones_mask_i == '0) &&
                       (subset_size_i == '0);
  assign sizes_agree = ($countones(subset_mask_i) == int'(subset_size_i)) &&
                       ($countones(low_ones_mask_i) == int'(subset_size_i)) &&
                       (subset_size_i != '0);
  assign low_contig  = ((low_ones_mask_i & (low_ones_mask_i + 1'b1)) == '0);

  // a done item carries no subset
  `KSE_ASSERT_MSG(a_done_zero, (res_valid_i && done_res_i) |-> fields_zero, "done item with nonzero fields")

  // a subset item has as many ones as its size, in both masks
  `KSE_ASSERT_MSG(a_size_match, (res_valid_i && !done_res_i) |-> sizes_agree, "subset size mismatch")

  // the low-ones mask is contiguous from bit zero
  `KSE_ASSERT(a_low_contig, res_valid_i |-> low_contig)

  // a stalled item holds its subset mask, size and done flag
  `KSE_ASSERT(a_res_hold, (res_valid_i && !res_ready_i) |=> (res_valid_i && $stable(subset_mask_i) && $stable(subset_size_i) && $stable(done_res_i)))

endmodule

bind k_subset_mask_enumerator kse_checker u_kse_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .res_valid_i     (res_o.valid),
  .res_ready_i     (res_o.ready),
  .subset_mask_i   (res_o.subset_mask),
  .low_ones_mask_i (res_o.low_ones_mask),
  .subset_size_i   (res_o.subset_size),
  .done_res_i      (res_o.done_res)
);
